// ----- hw/rtl/hco_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_pkg
// Shared types, constants and helper functions for the hardware cursor overlay:
// mode codes, register indexes, size clamping and the arrow sprite bitmap.
// ----------------------------------------------------------------------------
package hco_pkg;

  // coordinate and size widths
  localparam int POS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int DELTA_W = 8;
  localparam int COLOUR_W = 24;
  localparam logic [SIZE_W-1:0] POS_MAX = SIZE_W'(4096);

  // sprite placement window
  localparam int SPRITE_WIDTH  = 12;
  localparam int SPRITE_HEIGHT = 19;

  // arrow bitmap dimensions
  localparam int ROM_COLS = 12;
  localparam int ROM_ROWS = 19;
  localparam int COL_IDX_W = $clog2(ROM_COLS);
  localparam int ROW_IDX_W = $clog2(ROM_ROWS);
  localparam int HIT_COLS = (SPRITE_WIDTH < ROM_COLS) ? SPRITE_WIDTH : ROM_COLS;
  localparam int HIT_ROWS = (SPRITE_HEIGHT < ROM_ROWS) ? SPRITE_HEIGHT : ROM_ROWS;
  localparam int ROW_BITS = 2 * ROM_COLS;

  // colours
  localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 24'h000000;
  localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 24'hFFFFFF;

  // request modes
  typedef enum logic [1:0] {
    MODE_CENTER = 2'd0,
    MODE_MOVE   = 2'd1,
    MODE_PIXEL  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // sprite pixel codes
  typedef enum logic [1:0] {
    PIX_CLEAR    = 2'd0,
    PIX_BORDER   = 2'd1,
    PIX_INTERIOR = 2'd2,
    PIX_UNUSED   = 2'd3
  } pix_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // result of a pixel query
  typedef struct packed {
    logic                opaque;
    logic [COLOUR_W-1:0] colour;
  } pixel_hit_t;

  // zero counts as one, anything above the maximum counts as the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > POS_MAX) begin
      r = POS_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // add a signed delta and clamp to 0 .. size-1
  function automatic logic [POS_W-1:0] clamp_move(input logic [POS_W-1:0] pos,
                                                   input logic [DELTA_W-1:0] d,
                                                   input logic [SIZE_W-1:0] size);
    logic [SIZE_W:0] n;
    logic [SIZE_W-1:0] lim;
    logic [POS_W-1:0] r;
    n = {2'b00, pos} + {{(SIZE_W + 1 - DELTA_W){d[DELTA_W-1]}}, d};
    lim = size - SIZE_W'(1);
    if (n[SIZE_W]) begin
      r = '0;
    end else if (n[SIZE_W-1:0] >= size) begin
      r = lim[POS_W-1:0];
    end else begin
      r = n[POS_W-1:0];
    end
    return r;
  endfunction

  // arrow bitmap, one row per entry, column 0 in the top two bits
  function automatic logic [ROW_BITS-1:0] sprite_row(input logic [ROW_IDX_W-1:0] row);
    logic [ROW_BITS-1:0] r;
    case (row)
      5'd0:    r = 24'h400000;
      5'd1:    r = 24'h500000;
      5'd2:    r = 24'h640000;
      5'd3:    r = 24'h690000;
      5'd4:    r = 24'h6A4000;
      5'd5:    r = 24'h6A9000;
      5'd6:    r = 24'h6AA400;
      5'd7:    r = 24'h6AA900;
      5'd8:    r = 24'h6AAA40;
      5'd9:    r = 24'h6AAA90;
      5'd10:   r = 24'h6AAAA4;
      5'd11:   r = 24'h6AA955;
      5'd12:   r = 24'h699900;
      5'd13:   r = 24'h641900;
      5'd14:   r = 24'h500640;
      5'd15:   r = 24'h400190;
      5'd16:   r = 24'h000064;
      5'd17:   r = 24'h000014;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/hco_pixel_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hco_pixel_lookup
// Hit test of one screen pixel against the arrow sprite anchored at the
// cursor, with screen clipping; gives opacity and colour.
// ----------------------------------------------------------------------------
module hco_pixel_lookup import hco_pkg::*; (
  input  logic [POS_W-1:0]  pixel_x,
  input  logic [POS_W-1:0]  pixel_y,
  input  logic [POS_W-1:0]  column,
  input  logic [POS_W-1:0]  row,
  input  logic [SIZE_W-1:0] width,
  input  logic [SIZE_W-1:0] height,
  output pixel_hit_t        hit
);

  logic [POS_W-1:0]    di;
  logic [POS_W-1:0]    dj;
  logic                inside_sprite;
  logic                on_screen;
  logic [ROW_BITS-1:0] row_bits;
  logic [1:0]          code;
  logic [COL_IDX_W-1:0] col_idx;

  // offsets into the sprite
  assign di = pixel_x - column;
  assign dj = pixel_y - row;

  // window checks
  assign on_screen = ({1'b0, pixel_x} < width) && ({1'b0, pixel_y} < height);
  assign inside_sprite = (pixel_x >= column) && (pixel_y >= row) &&
                         (di < POS_W'(HIT_COLS)) && (dj < POS_W'(HIT_ROWS));

  // bitmap fetch
  assign row_bits = sprite_row(dj[ROW_IDX_W-1:0]);
  assign col_idx  = COL_IDX_W'(ROM_COLS - 1) - di[COL_IDX_W-1:0];
  assign code     = row_bits[{col_idx, 1'b0} +: 2];

  // opacity and colour
  always_comb begin
    hit.opaque = 1'b0;
    hit.colour = COLOUR_BLACK;
    if (on_screen && inside_sprite) begin
      case (code)
        PIX_BORDER: begin
          hit.opaque = 1'b1;
          hit.colour = COLOUR_BLACK;
        end
        PIX_INTERIOR: begin
          hit.opaque = 1'b1;
          hit.colour = COLOUR_WHITE;
        end
        default: begin
          hit.opaque = 1'b0;
          hit.colour = COLOUR_BLACK;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/hardware_cursor_overlay_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hardware_cursor_overlay_top
// An item passes the input register, then the result register, on its way
// from input transfer to result valid. Throughput: one item per cycle, limited
// only by the result register draining. Cursor position updates when an item
// leaves the input register. Reset (sync, active high) sets the cursor to 0,0
// and the screen size to 640x480 and empties both registers.
// ----------------------------------------------------------------------------
module hardware_cursor_overlay_top import hco_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [DELTA_W-1:0]   delta_x,
  input  logic [DELTA_W-1:0]   delta_y,
  input  logic [POS_W-1:0]     pixel_x,
  input  logic [POS_W-1:0]     pixel_y,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_W-1:0]     position_x,
  output logic [POS_W-1:0]     position_y,
  output logic                 opaque,
  output logic [COLOUR_W-1:0]  colour,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0]  screen_width;
  logic [SIZE_W-1:0]  screen_height;
  logic [POS_W-1:0]   column;
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   column_next;
  logic [POS_W-1:0]   row_next;
  logic               stage_valid;
  mode_t              stage_mode;
  logic [DELTA_W-1:0] stage_dx;
  logic [DELTA_W-1:0] stage_dy;
  logic [POS_W-1:0]   stage_px;
  logic [POS_W-1:0]   stage_py;
  logic [SIZE_W-1:0]  eff_w;
  logic [SIZE_W-1:0]  eff_h;
  logic               advance;
  logic               fire;
  pixel_hit_t         hit;
  pixel_hit_t         hit_res;

  // handshakes
  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !stage_valid || advance;
  assign fire      = stage_valid && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SIZE_W'(640);
      screen_height <= SIZE_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_mode <= mode_t'(mode);
      stage_dx   <= delta_x;
      stage_dy   <= delta_y;
      stage_px   <= pixel_x;
      stage_py   <= pixel_y;
    end
  end

  // effective screen size
  assign eff_w = eff_size(screen_width);
  assign eff_h = eff_size(screen_height);

  // cursor update
  always_comb begin
    column_next = column;
    row_next    = row;
    case (stage_mode)
      MODE_CENTER: begin
        column_next = eff_w[POS_W:1];
        row_next    = eff_h[POS_W:1];
      end
      MODE_MOVE: begin
        column_next = clamp_move(column, stage_dx, eff_w);
        row_next    = clamp_move(row, stage_dy, eff_h);
      end
      default: begin
        column_next = column;
        row_next    = row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (fire) begin
      column <= column_next;
      row    <= row_next;
    end
  end

  // sprite hit test against the current position
  hco_pixel_lookup u_lookup (
    .pixel_x (stage_px),
    .pixel_y (stage_py),
    .column  (column),
    .row     (row),
    .width   (eff_w),
    .height  (eff_h),
    .hit     (hit)
  );

  // only pixel queries report coverage
  always_comb begin
    hit_res = '0;
    if (stage_mode == MODE_PIXEL) begin
      hit_res = hit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      position_x <= column_next;
      position_y <= row_next;
      opaque     <= hit_res.opaque;
      colour     <= hit_res.colour;
    end
  end

  // a queued item is never dropped while the result side stalls
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid)
    else $error("queued item lost during stall");

  // uncovered results carry black
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !opaque |-> colour == COLOUR_BLACK)
    else $error("colour set on uncovered pixel");

  // recenter lands on half the effective width
  assert property (@(posedge clk) disable iff (rst)
    fire && stage_mode == MODE_CENTER |=> column == $past(eff_w[POS_W:1]))
    else $error("recenter column wrong");

  // a move keeps the cursor on screen
  assert property (@(posedge clk) disable iff (rst)
    fire && stage_mode == MODE_MOVE |=>
      ({1'b0, column} < $past(eff_w)) && ({1'b0, row} < $past(eff_h)))
    else $error("move left cursor off screen");

  // reported position matches the cursor registers
  assert property (@(posedge clk) disable iff (rst)
    fire |=> position_x == column && position_y == row)
    else $error("result position differs from cursor");

endmodule
